/* design/oqr_pkg.sv */
package oqr_pkg;

  // Default field widths
  localparam int PriceWidthDef = 31;
  localparam int QtyWidthDef   = 16;

  // Configuration port
  localparam int CfgDataWidth = 16;
  localparam int CfgIdxWidth  = 1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_LINK_READY = 1'd0,
    REG_ORDER_QTY  = 1'd1
  } cfg_reg_e;

  // Per-side quote phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_ACC = 2'd1,
    PH_RESTING  = 2'd2,
    PH_WAIT_CXL = 2'd3
  } phase_e;

  typedef enum logic {
    OP_TARGET = 1'b0,
    OP_RESULT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RK_ACCEPTED  = 2'd0,
    RK_CANCELLED = 2'd1,
    RK_REJECTED  = 2'd2,
    RK_FILL      = 2'd3
  } result_kind_e;

endpackage

/* design/order_quote_reconciler.sv */
// Order quote reconciler: keeps one quote per side (bid, ask) in line with the
// strategy's target price and the exchange's replies. Each input word is either
// a target price or an exchange result and sends at most one order word; an
// order quantity of 0 means cancel the resting order. Words are taken one per
// cycle, back to back, while the order stream does not stall; each passes an
// input register and one update stage that reads and writes the per-side
// state registers, and its order word is then held in the output register.
// That output register parts the two sides, and input keeps flowing while a
// result waits as long as that register is freed in the same cycle. The user must
// write configuration through cfg_we_i only while idle; the block does not enforce it.
module order_quote_reconciler import oqr_pkg::*; #(
  parameter int PRICE_WIDTH = PriceWidthDef,
  parameter int QTY_WIDTH   = QtyWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  // Input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata from bit 0: side, price, fill_qty, zero pad
  input  logic [((1+PRICE_WIDTH+QTY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser from bit 0: operation, result_kind
  input  logic [2:0]              s_axis_tuser,
  // Order stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // tdata from bit 0: order_side, order_price, order_qty, zero pad
  output logic [((1+PRICE_WIDTH+QTY_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int DataWidth = ((1 + PRICE_WIDTH + QTY_WIDTH + 7) / 8) * 8;
  localparam int PadWidth  = DataWidth - 1 - PRICE_WIDTH - QTY_WIDTH;
  localparam int PriceLo   = 1;
  localparam int QtyLo     = 1 + PRICE_WIDTH;

  // Configuration registers
  logic                    link_ready_q;
  logic [CfgDataWidth-1:0] order_qty_q;

  // Input stage
  logic                   in_valid_q;
  op_e                    in_op_q;
  result_kind_e           in_kind_q;
  logic                   in_side_q;
  logic [PRICE_WIDTH-1:0] in_price_q;
  logic [QTY_WIDTH-1:0]   in_fill_q;

  // Per-side state
  phase_e                 phase_q [2];
  logic [PRICE_WIDTH-1:0] live_q  [2];
  logic [QTY_WIDTH-1:0]   rem_q   [2];
  logic [PRICE_WIDTH-1:0] pend_q  [2];

  // Result stage
  logic                   out_valid_q;
  logic                   out_side_q;
  logic [PRICE_WIDTH-1:0] out_price_q;
  logic [QTY_WIDTH-1:0]   out_qty_q;

  // Update results
  phase_e                 phase_d;
  logic [PRICE_WIDTH-1:0] live_d;
  logic [QTY_WIDTH-1:0]   rem_d;
  logic [PRICE_WIDTH-1:0] pend_d;
  logic                   emit;
  logic [PRICE_WIDTH-1:0] ord_price;
  logic [QTY_WIDTH-1:0]   ord_qty;

  logic advance;
  logic in_take;
  logic upd;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign upd           = in_valid_q && advance;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ready_q <= 1'b0;
      order_qty_q  <= CfgDataWidth'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LINK_READY: link_ready_q <= cfg_data_i[0];
        REG_ORDER_QTY:  order_qty_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q    <= op_e'(s_axis_tuser[0]);
      in_kind_q  <= result_kind_e'(s_axis_tuser[2:1]);
      in_side_q  <= s_axis_tdata[0];
      in_price_q <= s_axis_tdata[PriceLo +: PRICE_WIDTH];
      in_fill_q  <= s_axis_tdata[QtyLo +: QTY_WIDTH];
    end
  end

  oqr_quote_update #(
    .PRICE_WIDTH(PRICE_WIDTH),
    .QTY_WIDTH  (QTY_WIDTH)
  ) u_update (
    .op_i           (in_op_q),
    .kind_i         (in_kind_q),
    .price_i        (in_price_q),
    .fill_qty_i     (in_fill_q),
    .link_ready_i   (link_ready_q),
    .order_qty_cfg_i(order_qty_q),
    .phase_i        (phase_q[in_side_q]),
    .live_i         (live_q[in_side_q]),
    .rem_i          (rem_q[in_side_q]),
    .pend_i         (pend_q[in_side_q]),
    .phase_o        (phase_d),
    .live_o         (live_d),
    .rem_o          (rem_d),
    .pend_o         (pend_d),
    .emit_o         (emit),
    .ord_price_o    (ord_price),
    .ord_qty_o      (ord_qty)
  );

  // Write back the selected side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        phase_q[i] <= PH_IDLE;
        live_q[i]  <= '0;
        rem_q[i]   <= '0;
        pend_q[i]  <= '0;
      end
    end else if (upd) begin
      phase_q[in_side_q] <= phase_d;
      live_q[in_side_q]  <= live_d;
      rem_q[in_side_q]   <= rem_d;
      pend_q[in_side_q]  <= pend_d;
    end
  end

  // Hold the order word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd && emit) begin
      out_side_q  <= in_side_q;
      out_price_q <= ord_price;
      out_qty_q   <= ord_qty;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  generate
    if (PadWidth > 0) begin : g_pad
      assign m_axis_tdata = {{PadWidth{1'b0}}, out_qty_q, out_price_q, out_side_q};
    end else begin : g_nopad
      assign m_axis_tdata = {out_qty_q, out_price_q, out_side_q};
    end
  endgenerate

  // A side waiting for acceptance always has quantity left
  a_wait_acc_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[0] == PH_WAIT_ACC) |-> (rem_q[0] != '0))
    else $error("bid side waits for acceptance with no quantity");

  a_wait_acc_rem_ask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[1] == PH_WAIT_ACC) |-> (rem_q[1] != '0))
    else $error("ask side waits for acceptance with no quantity");

  // A new order leaves its side waiting for acceptance
  a_new_order_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && emit && (ord_qty != '0)) |=> (phase_q[out_side_q] == PH_WAIT_ACC))
    else $error("new order sent without entering wait for acceptance");

  // A cancel leaves its side waiting for the cancel reply
  a_cancel_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && emit && (ord_qty == '0)) |=> (phase_q[out_side_q] == PH_WAIT_CXL))
    else $error("cancel sent without entering wait for cancel");

  // A stalled input word holds in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_price_q) && $stable(in_side_q)))
    else $error("input register changed while stalled");

endmodule

/* design/oqr_quote_update.sv */
// Next state of one side and the order it sends, for one word.
module oqr_quote_update import oqr_pkg::*; #(
  parameter int PRICE_WIDTH = PriceWidthDef,
  parameter int QTY_WIDTH   = QtyWidthDef
) (
  input  op_e                    op_i,
  input  result_kind_e           kind_i,
  input  logic [PRICE_WIDTH-1:0] price_i,
  input  logic [QTY_WIDTH-1:0]   fill_qty_i,
  input  logic                   link_ready_i,
  input  logic [CfgDataWidth-1:0] order_qty_cfg_i,
  input  phase_e                 phase_i,
  input  logic [PRICE_WIDTH-1:0] live_i,
  input  logic [QTY_WIDTH-1:0]   rem_i,
  input  logic [PRICE_WIDTH-1:0] pend_i,
  output phase_e                 phase_o,
  output logic [PRICE_WIDTH-1:0] live_o,
  output logic [QTY_WIDTH-1:0]   rem_o,
  output logic [PRICE_WIDTH-1:0] pend_o,
  output logic                   emit_o,
  output logic [PRICE_WIDTH-1:0] ord_price_o,
  output logic [QTY_WIDTH-1:0]   ord_qty_o
);

  logic [QTY_WIDTH-1:0]   qty_cfg;
  logic [QTY_WIDTH-1:0]   qty_eff;
  logic [QTY_WIDTH-1:0]   rem_fill;
  phase_e                 rec_phase;
  logic [PRICE_WIDTH-1:0] rec_target;
  logic                   do_rec;

  // Zero quantity register counts as one so an order never reads as a cancel
  assign qty_cfg = QTY_WIDTH'(order_qty_cfg_i);
  assign qty_eff = (qty_cfg == '0) ? QTY_WIDTH'(1) : qty_cfg;

  // Saturating fill decrement
  assign rem_fill = (fill_qty_i >= rem_i) ? '0 : (rem_i - fill_qty_i);

  always_comb begin
    phase_o     = phase_i;
    live_o      = live_i;
    rem_o       = rem_i;
    pend_o      = pend_i;
    emit_o      = 1'b0;
    ord_price_o = '0;
    ord_qty_o   = '0;
    rec_phase   = phase_i;
    rec_target  = price_i;
    do_rec      = 1'b0;

    // Apply target or result; accepted and cancelled re-quote the pending target
    if (op_i == OP_TARGET) begin
      do_rec = 1'b1;
    end else begin
      case (kind_i)
        RK_ACCEPTED: begin
          phase_o    = PH_RESTING;
          pend_o     = '0;
          rec_phase  = PH_RESTING;
          rec_target = pend_i;
          do_rec     = 1'b1;
        end
        RK_CANCELLED: begin
          phase_o    = PH_IDLE;
          pend_o     = '0;
          rec_phase  = PH_IDLE;
          rec_target = pend_i;
          do_rec     = 1'b1;
        end
        RK_FILL: begin
          if (price_i == live_i) begin
            rem_o = rem_fill;
            if (rem_fill == '0) begin
              phase_o = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Reconcile the quote with the target
    if (do_rec && link_ready_i && (rec_target != '0)) begin
      case (rec_phase)
        PH_IDLE: begin
          phase_o     = PH_WAIT_ACC;
          live_o      = rec_target;
          rem_o       = qty_eff;
          pend_o      = '0;
          emit_o      = 1'b1;
          ord_price_o = rec_target;
          ord_qty_o   = qty_eff;
        end
        PH_RESTING: begin
          if (live_i != rec_target) begin
            phase_o     = PH_WAIT_CXL;
            pend_o      = rec_target;
            emit_o      = 1'b1;
            ord_price_o = live_i;
            ord_qty_o   = '0;
          end
        end
        default: begin
          pend_o = rec_target;
        end
      endcase
    end
  end

endmodule

/* bench/tb_order_quote_reconciler.sv */
module tb_order_quote_reconciler;
  import oqr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = PriceWidthDef;
  localparam int QW = QtyWidthDef;
  localparam int DW = ((1 + PW + QW + 7) / 8) * 8;
  localparam int QuietLimit = 3000;
  localparam int SettleCycles = 6;
  localparam logic [PW-1:0] PxMax = {PW{1'b1}};
  localparam logic [QW-1:0] QtyMax = {QW{1'b1}};

  typedef struct {
    op_e            op;
    logic           sd;
    logic [PW-1:0]  px;
    result_kind_e   kind;
    logic [QW-1:0]  fqty;
  } quote_word_t;

  typedef struct {
    logic           sd;
    logic [PW-1:0]  px;
    logic [QW-1:0]  qty;
  } order_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  cfg_reg_e                cfg_idx_i = REG_LINK_READY;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // tdata from bit 0: side, price, fill_qty, zero pad
  logic [DW-1:0]           s_axis_tdata = '0;
  // tuser from bit 0: operation, result_kind
  logic [2:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // tdata from bit 0: order_side, order_price, order_qty, zero pad
  logic [DW-1:0]           m_axis_tdata;

  order_quote_reconciler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Words waiting to be sent and orders the block owes us
  quote_word_t words_to_send[$];
  order_t      orders_due[$];
  int unsigned words_queued = 0;
  int unsigned error_count = 0;
  bit          send_gaps = 1'b0;
  bit          take_stalls = 1'b0;
  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  int unsigned quiet_cycles = 0;

  // Shadow of the per-side quote state and the registers
  bit             link_up = 1'b0;
  logic [QW-1:0]  new_qty = 1;
  phase_e         quote_phase[2] = '{PH_IDLE, PH_IDLE};
  logic [PW-1:0]  live_px[2] = '{'0, '0};
  logic [QW-1:0]  left_qty[2] = '{'0, '0};
  logic [PW-1:0]  pend_px[2] = '{'0, '0};

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r = $urandom_range(99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  function automatic logic [PW-1:0] rand_price();
    logic [31:0] r;
    r = $urandom();
    return r[PW-1:0];
  endfunction

  function automatic logic [QW-1:0] rand_qty();
    logic [31:0] r;
    r = $urandom();
    return r[QW-1:0];
  endfunction

  // Move one side toward a target: place, cancel, or just remember it
  function automatic void quote_toward(input logic sd, input logic [PW-1:0] target);
    logic [QW-1:0] q;
    if (!link_up || target == '0) return;
    case (quote_phase[sd])
      PH_IDLE: begin
        q = (new_qty == '0) ? QW'(1) : new_qty;
        quote_phase[sd] = PH_WAIT_ACC;
        live_px[sd] = target;
        left_qty[sd] = q;
        pend_px[sd] = '0;
        orders_due.push_back('{sd, target, q});
      end
      PH_RESTING: begin
        if (live_px[sd] != target) begin
          quote_phase[sd] = PH_WAIT_CXL;
          pend_px[sd] = target;
          orders_due.push_back('{sd, live_px[sd], '0});
        end
      end
      default: pend_px[sd] = target;
    endcase
  endfunction

  // Update the shadow state for one accepted word
  function automatic void apply_word(input logic [2:0] user, input logic [DW-1:0] data);
    op_e           op;
    result_kind_e  kind;
    logic          sd;
    logic [PW-1:0] px;
    logic [PW-1:0] held;
    logic [QW-1:0] fq;
    op = op_e'(user[0]);
    kind = result_kind_e'(user[2:1]);
    sd = data[0];
    px = data[PW:1];
    fq = data[PW+QW:PW+1];
    if (op == OP_TARGET) begin
      quote_toward(sd, px);
      return;
    end
    case (kind)
      RK_ACCEPTED, RK_CANCELLED: begin
        quote_phase[sd] = (kind == RK_ACCEPTED) ? PH_RESTING : PH_IDLE;
        // clear pending before re-quoting it
        held = pend_px[sd];
        pend_px[sd] = '0;
        quote_toward(sd, held);
      end
      RK_FILL: begin
        if (px == live_px[sd]) begin
          left_qty[sd] = (fq >= left_qty[sd]) ? '0 : left_qty[sd] - fq;
          if (left_qty[sd] == '0) quote_phase[sd] = PH_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  // Sender: predict on accept, then load the next word after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    quote_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_word(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait != 0) begin
          s_axis_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (words_to_send.size() != 0) begin
          w = words_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= DW'({w.fqty, w.px, w.sd});
          s_axis_tuser <= {w.kind, w.op};
          send_wait <= pick_gap(send_gaps);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each order word, then stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    order_t      got;
    order_t      want;
    int unsigned stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_wait <= 0;
    end else begin
      stall = take_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        got.sd = m_axis_tdata[0];
        got.px = m_axis_tdata[PW:1];
        got.qty = m_axis_tdata[PW+QW:PW+1];
        if (orders_due.size() == 0) begin
          $error("order word with none expected: side %0d price %0d qty %0d",
                 got.sd, got.px, got.qty);
          error_count++;
        end else begin
          want = orders_due.pop_front();
          if (got.sd !== want.sd) begin
            $error("order_side: expected %0d, got %0d", want.sd, got.sd);
            error_count++;
          end
          if (got.px !== want.px) begin
            $error("order_price: expected %0d, got %0d", want.px, got.px);
            error_count++;
          end
          if (got.qty !== want.qty) begin
            $error("order_qty: expected %0d, got %0d", want.qty, got.qty);
            error_count++;
          end
        end
        stall = pick_gap(take_stalls);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        take_wait <= stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        take_wait <= 0;
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(input op_e op, input logic sd, input logic [PW-1:0] px,
                      input result_kind_e kind, input logic [QW-1:0] fqty);
    words_to_send.push_back('{op, sd, px, kind, fqty});
    words_queued++;
  endtask

  // Hold until every word is taken and every order has come back
  task automatic wait_drained();
    while (words_to_send.size() != 0 || s_axis_tvalid || orders_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_LINK_READY: link_up = data[0];
      default:        new_qty = data[QW-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic result_kind_e rand_kind();
    return result_kind_e'($urandom_range(3));
  endfunction

  function automatic logic [QW-1:0] fill_amount();
    if ($urandom_range(9) < 7) return QW'($urandom_range(4));
    return rand_qty();
  endfunction

  // Mostly place/accept/fill/replace sequences over a small price set, plus noise
  task automatic queue_random_words(input int unsigned count, input logic [PW-1:0] pool[4]);
    int unsigned   stop;
    logic          sd;
    logic [PW-1:0] p;
    logic [PW-1:0] p2;
    stop = words_queued + count;
    while (words_queued < stop) begin
      sd = $urandom_range(1);
      p = pool[$urandom_range(3)];
      p2 = pool[$urandom_range(3)];
      if ($urandom_range(99) < 70) begin
        send(OP_TARGET, sd, p, rand_kind(), rand_qty());
        send(OP_RESULT, sd, p, RK_ACCEPTED, rand_qty());
        case ($urandom_range(3))
          0: send(OP_RESULT, sd, p, RK_FILL, fill_amount());
          1: begin
            send(OP_TARGET, sd, p2, rand_kind(), rand_qty());
            if ($urandom_range(1)) send(OP_RESULT, sd, p, RK_REJECTED, rand_qty());
            send(OP_RESULT, sd, p, RK_CANCELLED, rand_qty());
          end
          2: begin
            send(OP_RESULT, sd, p, RK_FILL, fill_amount());
            send(OP_RESULT, sd, p, RK_FILL, fill_amount());
          end
          default: send(OP_TARGET, sd, p, rand_kind(), rand_qty());
        endcase
      end else begin
        send(op_e'($urandom_range(1)), sd, $urandom_range(1) ? p : rand_price(),
             rand_kind(), $urandom_range(1) ? fill_amount() : rand_qty());
      end
    end
  endtask

  initial begin
    logic [PW-1:0]  pool[4];
    logic [QW-1:0]  qty;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Link down after reset: targets ignored, results still move the phase
    send(OP_TARGET, 1'b0, 100, RK_ACCEPTED, '0);
    send(OP_RESULT, 1'b0, 100, RK_ACCEPTED, '0);
    send(OP_RESULT, 1'b0, 100, RK_CANCELLED, '0);
    wait_drained();

    // Zero order quantity acts as one; zero target, same price, cancel/replace
    cfg_write(REG_LINK_READY, 1);
    cfg_write(REG_ORDER_QTY, 0);
    take_stalls = 1'b1;
    send(OP_TARGET, 1'b0, PxMax, RK_ACCEPTED, QtyMax);
    send(OP_TARGET, 1'b0, '0, RK_ACCEPTED, '0);
    send(OP_RESULT, 1'b0, PxMax, RK_ACCEPTED, QtyMax);
    send(OP_TARGET, 1'b0, PxMax, RK_FILL, '0);
    send(OP_TARGET, 1'b0, 5, RK_ACCEPTED, '0);
    send(OP_TARGET, 1'b0, 6, RK_CANCELLED, '0);
    send(OP_RESULT, 1'b0, PxMax, RK_REJECTED, '0);
    send(OP_RESULT, 1'b0, PxMax, RK_CANCELLED, '0);
    send(OP_RESULT, 1'b0, 6, RK_FILL, '0);
    send(OP_RESULT, 1'b0, 6, RK_FILL, QtyMax);
    send(OP_RESULT, 1'b1, 12345, RK_FILL, 3);
    wait_drained();

    // Largest quantity, partial fill, then cancel pending with the link down
    cfg_write(REG_ORDER_QTY, QtyMax);
    send_gaps = 1'b1;
    send(OP_TARGET, 1'b1, 1, RK_ACCEPTED, '0);
    send(OP_RESULT, 1'b1, 1, RK_ACCEPTED, '0);
    send(OP_RESULT, 1'b1, 1, RK_FILL, 100);
    send(OP_TARGET, 1'b1, 2, RK_ACCEPTED, '0);
    wait_drained();
    cfg_write(REG_LINK_READY, 0);
    send(OP_RESULT, 1'b1, 1, RK_CANCELLED, '0);
    send(OP_TARGET, 1'b1, 7, RK_ACCEPTED, '0);
    wait_drained();
    cfg_write(REG_LINK_READY, 1);
    cfg_write(REG_ORDER_QTY, 3);
    send(OP_TARGET, 1'b1, 9, RK_FILL, QtyMax);
    send(OP_RESULT, 1'b1, 9, RK_ACCEPTED, '0);
    send(OP_RESULT, 1'b1, 9, RK_FILL, 2);
    send(OP_RESULT, 1'b1, 9, RK_FILL, 1);
    wait_drained();

    // Random phases, each with its own registers, prices and idling
    repeat (8) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(9))
          0:       pool[i] = '0;
          1:       pool[i] = PxMax;
          2:       pool[i] = 1;
          3, 4:    pool[i] = rand_price();
          default: pool[i] = PW'($urandom_range(6, 1));
        endcase
      end
      case ($urandom_range(9))
        0:       qty = '0;
        1:       qty = QtyMax;
        2:       qty = rand_qty();
        default: qty = QW'($urandom_range(6, 1));
      endcase
      cfg_write(REG_LINK_READY, ($urandom_range(9) != 0) ? 1 : 0);
      cfg_write(REG_ORDER_QTY, qty);
      send_gaps = ($urandom_range(2) != 0);
      take_stalls = ($urandom_range(2) != 0);
      queue_random_words(33, pool);
      // let the block run dry before the second half
      wait_drained();
      queue_random_words(33, pool);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/oqr_pkg.sv
design/oqr_quote_update.sv
design/order_quote_reconciler.sv
bench/tb_order_quote_reconciler.sv
